// ===== rtl/core/fnns_pkg.sv =====
// Shared types and constants for the four nearest neighbour selector.
package fnns_pkg;

    localparam int COORD_W   = 24;
    localparam int SQ_W      = 48;
    localparam int DIST_W    = 50;
    localparam int POS_W     = 12;
    localparam int OUT_SLOTS = 4;
    localparam int CFG_IDX_W = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [SQ_W-1:0]           t_sq;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic [POS_W-1:0]          t_pos;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ   = 1'b0,
        CFG_MIN_DIST_SQ = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_coord center_x;
        t_coord center_y;
        t_coord center_z;
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        logic   last_point;
    } t_in_item;

    typedef struct packed {
        t_pos  nearest_pos_0;
        t_pos  nearest_pos_1;
        t_pos  nearest_pos_2;
        t_pos  nearest_pos_3;
        t_dist nearest_dist_0;
        t_dist nearest_dist_1;
        t_dist nearest_dist_2;
        t_dist nearest_dist_3;
        logic  found_four;
        logic  too_many_points;
    } t_out_item;

    typedef struct packed {
        t_dist sq_dist;
        logic  last_point;
    } t_dist_item;

endpackage

// ===== rtl/core/fnns_dist.sv =====
// Three stage squared distance pipeline with per-stage valid and stall.
module fnns_dist (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fnns_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output fnns_pkg::t_dist_item o_dist
);

    function automatic fnns_pkg::t_sq square_diff(input fnns_pkg::t_coord a,
                                                  input fnns_pkg::t_coord b);
        logic signed [fnns_pkg::COORD_W:0] d;
        logic [fnns_pkg::COORD_W-1:0]      m;
        d = {b[fnns_pkg::COORD_W-1], b} - {a[fnns_pkg::COORD_W-1], a};
        m = d[fnns_pkg::COORD_W] ? fnns_pkg::COORD_W'(-d) : d[fnns_pkg::COORD_W-1:0];
        return fnns_pkg::SQ_W'(m) * fnns_pkg::SQ_W'(m);
    endfunction

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    fnns_pkg::t_in_item r_in1;
    fnns_pkg::t_sq      r_sq_x;
    fnns_pkg::t_sq      r_sq_y;
    fnns_pkg::t_sq      r_sq_z;
    logic               r_last2;
    fnns_pkg::t_dist    r_d3;
    logic               r_last3;
    fnns_pkg::t_sq      n_sq_x;
    fnns_pkg::t_sq      n_sq_y;
    fnns_pkg::t_sq      n_sq_z;
    fnns_pkg::t_dist    n_d3;
    logic               w_rdy1;
    logic               w_rdy2;
    logic               w_rdy3;

    assign w_rdy3  = !r_v3 || !i_stall;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    always_comb begin
        n_sq_x = square_diff(r_in1.center_x, r_in1.point_x);
        n_sq_y = square_diff(r_in1.center_y, r_in1.point_y);
        n_sq_z = square_diff(r_in1.center_z, r_in1.point_z);
        n_d3   = fnns_pkg::DIST_W'(r_sq_x) + fnns_pkg::DIST_W'(r_sq_y)
               + fnns_pkg::DIST_W'(r_sq_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_in1 <= i_item;
        end
        if (w_rdy2 && r_v1) begin
            r_sq_x  <= n_sq_x;
            r_sq_y  <= n_sq_y;
            r_sq_z  <= n_sq_z;
            r_last2 <= r_in1.last_point;
        end
        if (w_rdy3 && r_v2) begin
            r_d3    <= n_d3;
            r_last3 <= r_last2;
        end
    end

    assign o_valid           = r_v3;
    assign o_dist.sq_dist    = r_d3;
    assign o_dist.last_point = r_last3;

endmodule

// ===== rtl/core/four_nearest_neighbour_select.sv =====
// Top level of the four nearest neighbour selector: distance pipeline, sorted insert, result.
// The block takes one candidate point per cycle when unstalled. Each transfer passes the
// distance pipeline (input register, three 24 by 24 squarers, 50-bit sum) and then the
// selection stage, which compares the distance with every kept slot and inserts it into
// the kept registers as it fires; that insert against the kept list is what sets the rate
// of one item per cycle. The result of a last point reaches the output register after the
// input, squarer and sum registers, and the per-center state is clear for the very next item.
// A waiting result stalls the pipeline only when another last point reaches the selection stage.
module four_nearest_neighbour_select #(
    parameter int MAX_POINTS = 4096,
    parameter int NEIGHBOURS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fnns_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fnns_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [fnns_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fnns_pkg::DIST_W-1:0]         i_cfg_data
);

    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(NEIGHBOURS + 1);
    localparam logic [PW-1:0] POS_FULL  = PW'(MAX_POINTS);
    localparam logic [CW-1:0] COUNT_MAX = CW'(NEIGHBOURS);

    fnns_pkg::t_dist      r_cutoff_sq;
    fnns_pkg::t_dist      r_min_dist_sq;
    fnns_pkg::t_dist      r_best_dist [NEIGHBOURS];
    logic [IW-1:0]        r_best_pos  [NEIGHBOURS];
    logic [CW-1:0]        r_count;
    logic [PW-1:0]        r_stream_pos;
    logic                 r_overflow;
    logic                 r_out_valid;
    fnns_pkg::t_out_item  r_out_item;

    fnns_pkg::t_dist      n_best_dist [NEIGHBOURS];
    logic [IW-1:0]        n_best_pos  [NEIGHBOURS];
    logic [CW-1:0]        n_count;
    logic                 n_overflow;
    fnns_pkg::t_out_item  n_out_item;

    logic                 w_dvalid;
    logic                 w_dstall;
    fnns_pkg::t_dist_item w_ditem;
    logic                 w_fire;
    logic                 w_full;
    logic                 w_accept;
    logic [NEIGHBOURS-1:0] w_lt;
    fnns_pkg::t_pos       w_opos  [fnns_pkg::OUT_SLOTS];
    fnns_pkg::t_dist      w_odist [fnns_pkg::OUT_SLOTS];
    logic                 w_sorted;

    fnns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (w_dvalid),
        .i_stall (w_dstall),
        .o_dist  (w_ditem)
    );

    assign w_dstall = w_ditem.last_point && r_out_valid && i_out_stall;
    assign w_fire   = w_dvalid && !w_dstall;
    assign w_full   = (r_stream_pos == POS_FULL);
    assign w_accept = !w_full && (w_ditem.sq_dist > r_min_dist_sq)
                    && ((w_ditem.sq_dist < r_cutoff_sq) || (r_count != COUNT_MAX));

    always_comb begin
        for (int k = 0; k < NEIGHBOURS; k++) begin
            w_lt[k] = (k >= int'(r_count)) || (r_best_dist[k] > w_ditem.sq_dist);
        end
        for (int k = 0; k < NEIGHBOURS; k++) begin
            n_best_dist[k] = r_best_dist[k];
            n_best_pos[k]  = r_best_pos[k];
            if (w_accept && w_lt[k]) begin
                if (k == 0) begin
                    n_best_dist[k] = w_ditem.sq_dist;
                    n_best_pos[k]  = r_stream_pos[IW-1:0];
                end else if (!w_lt[k-1]) begin
                    n_best_dist[k] = w_ditem.sq_dist;
                    n_best_pos[k]  = r_stream_pos[IW-1:0];
                end else begin
                    n_best_dist[k] = r_best_dist[k-1];
                    n_best_pos[k]  = r_best_pos[k-1];
                end
            end
        end
        n_count    = (w_accept && (r_count != COUNT_MAX)) ? r_count + CW'(1) : r_count;
        n_overflow = r_overflow || w_full;
    end

    always_comb begin
        for (int k = 0; k < fnns_pkg::OUT_SLOTS; k++) begin
            w_opos[k]  = '0;
            w_odist[k] = '0;
        end
        for (int k = 0; k < NEIGHBOURS; k++) begin
            if (k < fnns_pkg::OUT_SLOTS && k < int'(n_count)) begin
                w_opos[k]  = fnns_pkg::t_pos'(n_best_pos[k]);
                w_odist[k] = n_best_dist[k];
            end
        end
        n_out_item.nearest_pos_0   = w_opos[0];
        n_out_item.nearest_pos_1   = w_opos[1];
        n_out_item.nearest_pos_2   = w_opos[2];
        n_out_item.nearest_pos_3   = w_opos[3];
        n_out_item.nearest_dist_0  = w_odist[0];
        n_out_item.nearest_dist_1  = w_odist[1];
        n_out_item.nearest_dist_2  = w_odist[2];
        n_out_item.nearest_dist_3  = w_odist[3];
        n_out_item.found_four      = (n_count == COUNT_MAX);
        n_out_item.too_many_points = n_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq   <= '0;
            r_min_dist_sq <= fnns_pkg::DIST_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fnns_pkg::CFG_CUTOFF_SQ:   r_cutoff_sq   <= i_cfg_data;
                fnns_pkg::CFG_MIN_DIST_SQ: r_min_dist_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_stream_pos <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fire) begin
                if (w_ditem.last_point) begin
                    r_count      <= '0;
                    r_stream_pos <= '0;
                    r_overflow   <= 1'b0;
                end else begin
                    r_count    <= n_count;
                    r_overflow <= n_overflow;
                    if (!w_full) begin
                        r_stream_pos <= r_stream_pos + PW'(1);
                    end
                end
            end
            if (w_fire && w_ditem.last_point) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_best_dist <= n_best_dist;
            r_best_pos  <= n_best_pos;
            if (w_ditem.last_point) begin
                r_out_item <= n_out_item;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        w_sorted = 1'b1;
        for (int k = 1; k < NEIGHBOURS; k++) begin
            if (k < int'(r_count) && r_best_dist[k-1] > r_best_dist[k]) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("accepted count above neighbour count");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stream_pos <= POS_FULL)
        else $error("stream position above capacity");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_ditem.last_point |=> r_count == '0 && r_stream_pos == '0 && !r_overflow)
        else $error("center state not cleared after last point");

    a_kept_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sorted)
        else $error("kept distances out of order");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_item))
        else $error("pending result overwritten or dropped");

endmodule
